// File: sv/se3te_pkg.sv
// ----------------------------------------------------------------------------
// se3te_pkg
// Shared types, fixed-point helpers and elaboration-time constants for the
// SE(3) twist exponential pipeline.
// ----------------------------------------------------------------------------
package se3te_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;
    // CORDIC working format: signed, 61 fractional bits
    localparam int WFRAC      = 61;
    localparam int WW         = 64;
    localparam int CORDIC_N   = FRAC_BITS + 4;
    localparam int ZSHIFT     = WFRAC - FRAC_BITS;
    // quotient bits of |q| / 2pi
    localparam int RED_STEPS  = DATA_WIDTH - FRAC_BITS - 3;
    localparam int MUL_LAT    = 2;

    typedef logic signed [DATA_WIDTH-1:0] fix_t;
    typedef logic        [DATA_WIDTH-1:0] ufix_t;
    typedef logic signed [DATA_WIDTH+1:0] wide_t;
    typedef logic signed [WW-1:0]         cw_t;

    localparam cw_t PI_W      = 64'sh6487ED5110B4611A;
    localparam cw_t TWO_PI_W  = (PI_W + (64'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
    localparam cw_t PI_F_W    = (PI_W + (64'sd1 <<< (60 - FRAC_BITS))) >>> (WFRAC - FRAC_BITS);
    localparam cw_t HALF_PI_W = PI_W >>> 1;
    localparam cw_t GAIN_X0   = 64'sh9B74EDA8 <<< (WFRAC - 32);
    localparam cw_t ROUND_W   = 64'sd1 <<< (ZSHIFT - 1);

    localparam fix_t  ONE_F    = fix_t'(64'sd1 <<< FRAC_BITS);
    localparam fix_t  TWO_PI_F = fix_t'(TWO_PI_W);
    localparam fix_t  PI_F     = fix_t'(PI_F_W);
    localparam ufix_t TWO_PI_U = ufix_t'(TWO_PI_W);

    typedef struct packed {
        fix_t       q;
        fix_t [2:0] v;
        fix_t [2:0] w;
    } twist_t;

    typedef struct packed {
        twist_t tw;
        fix_t   s;
        fix_t   c;
    } sc_t;

    typedef struct packed {
        fix_t [2:0] trans;
        fix_t [8:0] rot;
    } xform_t;

    function automatic wide_t ext2(input fix_t x);
        return {{2{x[DATA_WIDTH-1]}}, x};
    endfunction

    // clamp a sum of up to three terms to the field range
    function automatic fix_t sat(input wide_t x);
        fix_t r;
        if (x[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b000 || x[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b111)
            r = x[DATA_WIDTH-1:0];
        else if (x[DATA_WIDTH+1])
            r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        return r;
    endfunction

    // restoring division, elaboration use only
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] qv;
        logic [64:0] rv;
        qv = '0;
        rv = '0;
        for (int b = 63; b >= 0; b--) begin
            rv = {rv[63:0], n[b]};
            if (rv >= {1'b0, d}) begin
                rv    = rv - {1'b0, d};
                qv[b] = 1'b1;
            end
        end
        return qv;
    endfunction

    // arctan(2^-i) from the truncated series
    function automatic cw_t atan_w(input int i);
        cw_t acc;
        cw_t term;
        int  e;
        acc = '0;
        if (i == 0) begin
            acc = PI_W >>> 2;
        end
        else begin
            for (int k = 0; k < 32; k++) begin
                e = i * (2 * k + 1);
                if (e <= WFRAC) begin
                    term = cw_t'(udiv(64'd1 << (WFRAC - e), 64'(2 * k + 1)));
                    acc  = ((k % 2) == 1) ? acc - term : acc + term;
                end
            end
        end
        return acc;
    endfunction

endpackage

// File: sv/se3te_mul.sv
// ----------------------------------------------------------------------------
// se3te_mul
// Two-stage fixed-point multiplier: magnitude product, then round half away
// from zero and saturate.
// ----------------------------------------------------------------------------
module se3te_mul (
    input  logic            clk,
    input  logic            en,
    input  se3te_pkg::fix_t a,
    input  se3te_pkg::fix_t b,
    output se3te_pkg::fix_t p
);

    localparam int DW = se3te_pkg::DATA_WIDTH;
    localparam int FB = se3te_pkg::FRAC_BITS;
    localparam int MW = 2 * DW - FB;

    logic [DW-1:0]   ua;
    logic [DW-1:0]   ub;
    logic [2*DW-1:0] prod_reg;
    logic            neg_reg;
    logic [2*DW-1:0] rsum;
    logic [MW-1:0]   mag;
    logic [MW-1:0]   mag_c;
    se3te_pkg::fix_t p_next;
    se3te_pkg::fix_t p_reg;

    localparam logic [MW-1:0] LIM = MW'(1) << (DW - 1);

    always_comb
    begin
        ua = a[DW-1] ? DW'(-a) : DW'(a);
        ub = b[DW-1] ? DW'(-b) : DW'(b);
    end

    always_comb
    begin
        rsum = prod_reg + ((2*DW)'(1) << (FB - 1));
        mag  = rsum[2*DW-1:FB];
        if (neg_reg)
        begin
            mag_c  = (mag > LIM) ? LIM : mag;
            p_next = se3te_pkg::fix_t'(-mag_c[DW-1:0]);
        end
        else
        begin
            mag_c  = (mag > LIM - 1'b1) ? LIM - 1'b1 : mag;
            p_next = se3te_pkg::fix_t'(mag_c[DW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= ua * ub;
            neg_reg  <= a[DW-1] ^ b[DW-1];
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: sv/se3te_sincos.sv
// ----------------------------------------------------------------------------
// se3te_sincos
// Angle reduction by 2pi one quotient bit per stage, quadrant fold, then a
// fully unrolled rotation-mode CORDIC, one iteration per stage.
// ----------------------------------------------------------------------------
module se3te_sincos (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  se3te_pkg::twist_t   in_item,
    output logic                out_valid,
    output se3te_pkg::sc_t      out_item
);

    localparam int DW = se3te_pkg::DATA_WIDTH;
    localparam int NR = se3te_pkg::RED_STEPS;
    localparam int NC = se3te_pkg::CORDIC_N;
    localparam int NS = NR + NC + 4;
    // stage holding the folded angle
    localparam int ST_F2 = NR + 2;

    logic                vld_reg [NS];
    se3te_pkg::twist_t   tw_reg  [NS];
    se3te_pkg::ufix_t    mag_reg [NR+1];
    logic                neg_reg [NR+1];
    se3te_pkg::fix_t     r_reg;
    se3te_pkg::fix_t     r_next;
    se3te_pkg::fix_t     r_s;
    se3te_pkg::cw_t      z0_reg;
    se3te_pkg::cw_t      z0_next;
    se3te_pkg::cw_t      zr;
    logic                flip0_reg;
    logic                flip0_next;
    se3te_pkg::cw_t      x_reg   [NC];
    se3te_pkg::cw_t      y_reg   [NC];
    se3te_pkg::cw_t      z_reg   [NC];
    logic                flip_reg[NC];
    se3te_pkg::cw_t      xf;
    se3te_pkg::cw_t      s_w;
    se3te_pkg::cw_t      c_w;
    se3te_pkg::fix_t     s_reg;
    se3te_pkg::fix_t     c_reg;

    // valid bits and carried item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tw_reg[0] <= in_item;
            for (int i = 1; i < NS; i++)
                tw_reg[i] <= tw_reg[i-1];
            mag_reg[0] <= in_item.q[DW-1] ? DW'(-in_item.q) : DW'(in_item.q);
            neg_reg[0] <= in_item.q[DW-1];
        end
    end

    // |q| mod 2pi, highest quotient bit first
    for (genvar j = 0; j < NR; j++) begin : g_red
        localparam se3te_pkg::ufix_t SUB = se3te_pkg::TWO_PI_U << (NR - 1 - j);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[j+1] <= (mag_reg[j] >= SUB) ? mag_reg[j] - SUB : mag_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    // restore sign, move into [-pi, pi]
    always_comb
    begin
        r_s = neg_reg[NR] ? se3te_pkg::fix_t'(-mag_reg[NR]) : se3te_pkg::fix_t'(mag_reg[NR]);
        if (r_s > se3te_pkg::PI_F)
            r_next = r_s - se3te_pkg::TWO_PI_F;
        else if (r_s < -se3te_pkg::PI_F)
            r_next = r_s + se3te_pkg::TWO_PI_F;
        else
            r_next = r_s;
    end

    // fold into [-pi/2, pi/2], flip cos
    always_comb
    begin
        zr = se3te_pkg::cw_t'(r_reg) <<< se3te_pkg::ZSHIFT;
        if (zr > se3te_pkg::HALF_PI_W)
        begin
            z0_next    = se3te_pkg::PI_W - zr;
            flip0_next = 1'b1;
        end
        else if (zr < -se3te_pkg::HALF_PI_W)
        begin
            z0_next    = -se3te_pkg::PI_W - zr;
            flip0_next = 1'b1;
        end
        else
        begin
            z0_next    = zr;
            flip0_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_next;
            z0_reg    <= z0_next;
            flip0_reg <= flip0_next;
        end
    end

    for (genvar i = 0; i < NC; i++) begin : g_cordic
        localparam se3te_pkg::cw_t ATAN = se3te_pkg::atan_w(i);
        se3te_pkg::cw_t xi;
        se3te_pkg::cw_t yi;
        se3te_pkg::cw_t zi;
        logic           fi;
        if (i == 0) begin : g_first
            assign xi = se3te_pkg::GAIN_X0;
            assign yi = '0;
            assign zi = z0_reg;
            assign fi = flip0_reg;
        end
        else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign fi = flip_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[se3te_pkg::WW-1])
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - ATAN;
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + ATAN;
                end
                flip_reg[i] <= fi;
            end
        end
    end

    // round half up to the field format
    always_comb
    begin
        xf  = flip_reg[NC-1] ? -x_reg[NC-1] : x_reg[NC-1];
        s_w = (y_reg[NC-1] + se3te_pkg::ROUND_W) >>> se3te_pkg::ZSHIFT;
        c_w = (xf + se3te_pkg::ROUND_W) >>> se3te_pkg::ZSHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_w[DW-1:0];
            c_reg <= c_w[DW-1:0];
        end
    end

    assign out_valid   = vld_reg[NS-1];
    assign out_item.tw = tw_reg[NS-1];
    assign out_item.s  = s_reg;
    assign out_item.c  = c_reg;

    // remainder must be below 2pi once the last quotient bit is taken
    a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NR] |-> (mag_reg[NR] < se3te_pkg::TWO_PI_U))
        else $error("angle remainder out of range");

    // fold leaves the CORDIC angle within a quarter turn
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_F2] |-> (z0_reg <= se3te_pkg::HALF_PI_W && z0_reg >= -se3te_pkg::HALF_PI_W))
        else $error("folded angle out of range");

    a_flip_carry: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[ST_F2] |=> flip_reg[0] == $past(flip0_reg))
        else $error("cos flip lost entering CORDIC");

endmodule

// File: sv/se3te_rodrigues.sv
// ----------------------------------------------------------------------------
// se3te_rodrigues
// Builds [w], [w]^2 and the rotation and translation matrices from sin and
// cos, then multiplies the translation matrix by v.
// ----------------------------------------------------------------------------
module se3te_rodrigues (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  se3te_pkg::sc_t   in_item,
    output logic             out_valid,
    output se3te_pkg::xform_t out_item
);

    localparam int RL = 9;

    logic              vld_reg [RL];

    se3te_pkg::fix_t   c1_reg [2];
    se3te_pkg::fix_t   qs_reg [2];
    se3te_pkg::fix_t   s_reg  [2];
    se3te_pkg::fix_t   nw_reg [2][3];
    se3te_pkg::twist_t tw_reg [2];

    se3te_pkg::fix_t   c1_r3;
    se3te_pkg::fix_t   qs_r3;
    se3te_pkg::fix_t   s_r3;
    se3te_pkg::fix_t   nw_r3 [3];
    se3te_pkg::fix_t   w_r3  [3];
    se3te_pkg::fix_t   dg_r3 [3];
    se3te_pkg::fix_t   od_r3 [3];
    se3te_pkg::fix_t   q_r3;
    se3te_pkg::fix_t   q_r4;
    se3te_pkg::fix_t   q_r5;
    se3te_pkg::fix_t [2:0] v_r3;
    se3te_pkg::fix_t [2:0] v_r4;
    se3te_pkg::fix_t [2:0] v_r5;
    se3te_pkg::fix_t [2:0] v_r6;

    se3te_pkg::fix_t   pa [6];
    se3te_pkg::fix_t   kk  [9];
    se3te_pkg::fix_t   kk2 [9];
    se3te_pkg::fix_t   p_sk  [9];
    se3te_pkg::fix_t   p_ck  [9];
    se3te_pkg::fix_t   p_ck2 [9];
    se3te_pkg::fix_t   p_qk2 [9];
    se3te_pkg::fix_t   p_mv  [9];

    se3te_pkg::fix_t   rot_r6 [9];
    se3te_pkg::fix_t [8:0] rot_r7;
    se3te_pkg::fix_t [8:0] rot_r8;
    se3te_pkg::fix_t [8:0] rot_r9;
    se3te_pkg::fix_t   m_r6 [9];
    se3te_pkg::fix_t [2:0] tr_r9;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RL; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < RL; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // 1 - cos, q - sin, negated axis; held alongside the w products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg[0] <= se3te_pkg::sat(se3te_pkg::ext2(se3te_pkg::ONE_F)
                                        - se3te_pkg::ext2(in_item.c));
            qs_reg[0] <= se3te_pkg::sat(se3te_pkg::ext2(in_item.tw.q)
                                        - se3te_pkg::ext2(in_item.s));
            s_reg[0]  <= in_item.s;
            tw_reg[0] <= in_item.tw;
            for (int i = 0; i < 3; i++)
                nw_reg[0][i] <= se3te_pkg::sat(-se3te_pkg::ext2(in_item.tw.w[i]));
            c1_reg[1] <= c1_reg[0];
            qs_reg[1] <= qs_reg[0];
            s_reg[1]  <= s_reg[0];
            tw_reg[1] <= tw_reg[0];
            for (int i = 0; i < 3; i++)
                nw_reg[1][i] <= nw_reg[0][i];
        end
    end

    // w products: squares, then w0w1, w0w2, w1w2
    se3te_mul u_mul_a0 (.clk(clk), .en(en), .a(in_item.tw.w[0]), .b(in_item.tw.w[0]), .p(pa[0]));
    se3te_mul u_mul_a1 (.clk(clk), .en(en), .a(in_item.tw.w[1]), .b(in_item.tw.w[1]), .p(pa[1]));
    se3te_mul u_mul_a2 (.clk(clk), .en(en), .a(in_item.tw.w[2]), .b(in_item.tw.w[2]), .p(pa[2]));
    se3te_mul u_mul_a3 (.clk(clk), .en(en), .a(in_item.tw.w[0]), .b(in_item.tw.w[1]), .p(pa[3]));
    se3te_mul u_mul_a4 (.clk(clk), .en(en), .a(in_item.tw.w[0]), .b(in_item.tw.w[2]), .p(pa[4]));
    se3te_mul u_mul_a5 (.clk(clk), .en(en), .a(in_item.tw.w[1]), .b(in_item.tw.w[2]), .p(pa[5]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dg_r3[0] <= se3te_pkg::sat(-se3te_pkg::ext2(pa[2]) - se3te_pkg::ext2(pa[1]));
            dg_r3[1] <= se3te_pkg::sat(-se3te_pkg::ext2(pa[0]) - se3te_pkg::ext2(pa[2]));
            dg_r3[2] <= se3te_pkg::sat(-se3te_pkg::ext2(pa[0]) - se3te_pkg::ext2(pa[1]));
            od_r3[0] <= pa[3];
            od_r3[1] <= pa[4];
            od_r3[2] <= pa[5];
            c1_r3    <= c1_reg[1];
            qs_r3    <= qs_reg[1];
            s_r3     <= s_reg[1];
            q_r3     <= tw_reg[1].q;
            v_r3     <= tw_reg[1].v;
            for (int i = 0; i < 3; i++)
            begin
                nw_r3[i] <= nw_reg[1][i];
                w_r3[i]  <= tw_reg[1].w[i];
            end
            q_r4 <= q_r3;
            v_r4 <= v_r3;
            q_r5 <= q_r4;
            v_r5 <= v_r4;
        end
    end

    // [w] and [w]^2, row major
    always_comb
    begin
        kk[0] = '0;       kk[1] = nw_r3[2]; kk[2] = w_r3[1];
        kk[3] = w_r3[2];  kk[4] = '0;       kk[5] = nw_r3[0];
        kk[6] = nw_r3[1]; kk[7] = w_r3[0];  kk[8] = '0;
        kk2[0] = dg_r3[0]; kk2[1] = od_r3[0]; kk2[2] = od_r3[1];
        kk2[3] = od_r3[0]; kk2[4] = dg_r3[1]; kk2[5] = od_r3[2];
        kk2[6] = od_r3[1]; kk2[7] = od_r3[2]; kk2[8] = dg_r3[2];
    end

    for (genvar ij = 0; ij < 9; ij++) begin : g_mat
        if ((ij / 3) != (ij % 3)) begin : g_off
            se3te_mul u_mul_sk (.clk(clk), .en(en), .a(s_r3),  .b(kk[ij]), .p(p_sk[ij]));
            se3te_mul u_mul_ck (.clk(clk), .en(en), .a(c1_r3), .b(kk[ij]), .p(p_ck[ij]));
        end
        else begin : g_diag
            assign p_sk[ij] = '0;
            assign p_ck[ij] = '0;
        end
        se3te_mul u_mul_ck2 (.clk(clk), .en(en), .a(c1_r3), .b(kk2[ij]), .p(p_ck2[ij]));
        se3te_mul u_mul_qk2 (.clk(clk), .en(en), .a(qs_r3), .b(kk2[ij]), .p(p_qk2[ij]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rot_r6[ij] <= se3te_pkg::sat(
                    se3te_pkg::ext2(((ij / 3) == (ij % 3)) ? se3te_pkg::ONE_F : '0)
                    + se3te_pkg::ext2(p_sk[ij]) + se3te_pkg::ext2(p_ck2[ij]));
                m_r6[ij] <= se3te_pkg::sat(
                    se3te_pkg::ext2(((ij / 3) == (ij % 3)) ? q_r5 : '0)
                    + se3te_pkg::ext2(p_ck[ij]) + se3te_pkg::ext2(p_qk2[ij]));
            end
        end

        se3te_mul u_mul_mv (.clk(clk), .en(en), .a(m_r6[ij]), .b(v_r6[ij % 3]), .p(p_mv[ij]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_r6   <= v_r5;
            for (int i = 0; i < 9; i++)
                rot_r7[i] <= rot_r6[i];
            rot_r8 <= rot_r7;
            rot_r9 <= rot_r8;
            for (int i = 0; i < 3; i++)
                tr_r9[i] <= se3te_pkg::sat(se3te_pkg::ext2(p_mv[3*i])
                                           + se3te_pkg::ext2(p_mv[3*i+1])
                                           + se3te_pkg::ext2(p_mv[3*i+2]));
        end
    end

    assign out_valid      = vld_reg[RL-1];
    assign out_item.rot   = rot_r9;
    assign out_item.trans = tr_r9;

endmodule

// File: sv/se3_twist_exponential_top.sv
// ----------------------------------------------------------------------------
// se3_twist_exponential_top
// SE(3) exponential of a screw axis and joint angle, Rodrigues form, Q8.24.
//
//   channel  | dir | width | contents
//   s_*      | in  | 224   | axis w, linear v, angle
//   m_*      | out | 384   | rotation row major, translation
//
// One request per cycle while m_* does not stall; a request goes through angle
// reduction, the 28-iteration CORDIC, the matrix multipliers and the output reg.
// Reset clears the valid bits only; no other state.
// A stall on m_* holds the pipeline once the output skid register fills;
// s_tready depends on that register alone, nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module se3_twist_exponential_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // axis_wx, axis_wy, axis_wz, lin_vx, lin_vy, lin_vz, angle
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_00 .. rot_22, trans_x, trans_y, trans_z
    output logic [383:0] m_tdata
);

    localparam int DW = se3te_pkg::DATA_WIDTH;

    logic                 en;
    se3te_pkg::twist_t    in_item;
    logic                 sc_valid;
    se3te_pkg::sc_t       sc_item;
    logic                 pipe_valid;
    se3te_pkg::xform_t    pipe_item;
    logic                 pipe_take;
    logic                 out_valid_reg;
    se3te_pkg::xform_t    out_reg;
    logic                 skid_valid_reg;
    se3te_pkg::xform_t    skid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_item.w[i] = s_tdata[DW*i +: DW];
            in_item.v[i] = s_tdata[DW*(3+i) +: DW];
        end
        in_item.q = s_tdata[DW*6 +: DW];
    end

    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign pipe_take = en && pipe_valid;

    se3te_sincos u_sincos (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_item  (in_item),
        .out_valid(sc_valid),
        .out_item (sc_item)
    );

    se3te_rodrigues u_rodrigues (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sc_valid),
        .in_item  (sc_item),
        .out_valid(pipe_valid),
        .out_item (pipe_item)
    );

    // output register with skid: park a request that arrives while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_take;
            end
        end
        else if (pipe_take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_reg <= skid_valid_reg ? skid_reg : pipe_item;
        else if (pipe_take)
            skid_reg <= pipe_item;
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            m_tdata[DW*i +: DW] = out_reg.rot[i];
        for (int i = 0; i < 3; i++)
            m_tdata[DW*(9+i) +: DW] = out_reg.trans[i];
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request with the output empty");

    a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready && !skid_valid_reg && pipe_valid |=> skid_valid_reg)
        else $error("stalled request not parked");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid request not moved to output");

endmodule
